// ----- sv/vfcm_pkg.sv -----
`timescale 1ns / 1ps

package vfcm_pkg;

  // Sequencer states, one-hot.
  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_CENTER = 5'b00100,
    ST_PROBE  = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_t;

  // Request codes of the input word.
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_MESH  = 2'd1;
  localparam logic [1:0] REQ_START = 2'd2;

  // Face directions, in emission order.
  localparam logic [2:0] DIR_LEFT   = 3'd0;
  localparam logic [2:0] DIR_RIGHT  = 3'd1;
  localparam logic [2:0] DIR_BOTTOM = 3'd2;
  localparam logic [2:0] DIR_TOP    = 3'd3;
  localparam logic [2:0] DIR_BACK   = 3'd4;
  localparam logic [2:0] DIR_FRONT  = 3'd5;
  localparam logic [2:0] DIR_END    = 3'd6;
  localparam int         NUM_DIRS   = 6;

  // Color selectors.
  localparam logic [1:0] COLOR_WHITE = 2'd0;
  localparam logic [1:0] COLOR_GREEN = 2'd1;
  localparam logic [1:0] COLOR_BLUE  = 2'd2;

  // Field widths.
  localparam int COORD_W   = 4;
  localparam int IN_KIND_W = 8;
  localparam int DIR_W     = 3;
  localparam int COLOR_W   = 2;
  localparam int VCOUNT_W  = 17;

  localparam logic [VCOUNT_W-1:0] VERTS_PER_FACE = 17'd4;

endpackage

// ----- sv/voxel_face_culling_mesher_core.sv -----
`timescale 1ns / 1ps

// Channel   Ports                                   Handshake
// input     in_req_type in_pos_x/y/z in_kind_in     start high, busy low
// result    out_face_dir .. out_last_face           out_valid for one cycle
//
// A write or start word leaves busy low.
// A mesh word for a voxel inside the chunk keeps busy high through one store read each
// for the voxel and its six neighbors, then one emit per visible face; if the voxel is
// empty, busy drops after the center read. After reset, busy stays high while the store
// is swept to zero, one entry per cycle, CHUNK_EDGE**3 entries (4096 by default).
// Results cannot be stalled; each face word is shown for exactly one cycle.

module voxel_face_culling_mesher_core #(
  parameter int CHUNK_EDGE = 16,
  parameter int KIND_BITS  = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_req_type,
  input  logic [vfcm_pkg::COORD_W-1:0]  in_pos_x,
  input  logic [vfcm_pkg::COORD_W-1:0]  in_pos_y,
  input  logic [vfcm_pkg::COORD_W-1:0]  in_pos_z,
  input  logic [vfcm_pkg::IN_KIND_W-1:0] in_kind_in,
  output logic                          out_valid,
  output logic [vfcm_pkg::DIR_W-1:0]    out_face_dir,
  output logic [vfcm_pkg::COORD_W-1:0]  out_face_x,
  output logic [vfcm_pkg::COORD_W-1:0]  out_face_y,
  output logic [vfcm_pkg::COORD_W-1:0]  out_face_z,
  output logic [vfcm_pkg::VCOUNT_W-1:0] out_first_vertex,
  output logic [vfcm_pkg::COLOR_W-1:0]  out_color_sel,
  output logic                          out_last_face
);

  import vfcm_pkg::*;

  localparam int DEPTH = CHUNK_EDGE * CHUNK_EDGE * CHUNK_EDGE;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = $clog2(CHUNK_EDGE) + 2;

  localparam logic [AW-1:0] EE_A     = AW'(CHUNK_EDGE * CHUNK_EDGE);
  localparam logic [AW-1:0] E_A      = AW'(CHUNK_EDGE);
  localparam logic [AW-1:0] LAST_A   = AW'(DEPTH - 1);
  localparam logic [NW-1:0] E_N      = NW'(CHUNK_EDGE);
  localparam logic [NW-1:0] ONE_N    = NW'(1);
  localparam logic [6:0]    EDGE_C   = 7'(CHUNK_EDGE);

  // Linear store address of a coordinate triple.
  function automatic logic [AW-1:0] addr_of(input logic [NW-1:0] x,
                                            input logic [NW-1:0] y,
                                            input logic [NW-1:0] z);
    addr_of = AW'(x) * EE_A + AW'(y) * E_A + AW'(z);
  endfunction

  state_t                state_r, state_nxt;
  logic [AW-1:0]         clr_addr_r, clr_addr_nxt;
  logic [COORD_W-1:0]    pos_x_r, pos_x_nxt;
  logic [COORD_W-1:0]    pos_y_r, pos_y_nxt;
  logic [COORD_W-1:0]    pos_z_r, pos_z_nxt;
  logic [DIR_W-1:0]      issue_dir_r, issue_dir_nxt;
  logic                  ret_vld_r, ret_vld_nxt;
  logic [DIR_W-1:0]      ret_dir_r, ret_dir_nxt;
  logic                  ret_oob_r, ret_oob_nxt;
  logic [NUM_DIRS-1:0]   mask_r, mask_nxt;
  logic [VCOUNT_W-1:0]   vcount_r, vcount_nxt;
  logic [COLOR_W-1:0]    color_r, color_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [DIR_W-1:0]      out_dir_r, out_dir_nxt;
  logic [COORD_W-1:0]    out_x_r, out_x_nxt;
  logic [COORD_W-1:0]    out_y_r, out_y_nxt;
  logic [COORD_W-1:0]    out_z_r, out_z_nxt;
  logic [VCOUNT_W-1:0]   out_vtx_r, out_vtx_nxt;
  logic [COLOR_W-1:0]    out_color_r, out_color_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  accept;
  logic                  in_inside;
  logic [NW-1:0]         nb_x, nb_y, nb_z;
  logic                  nb_oob;
  logic                  mem_we;
  logic [AW-1:0]         mem_addr;
  logic [KIND_BITS-1:0]  mem_wdata;
  logic [KIND_BITS-1:0]  mem_rdata_r;
  logic [KIND_BITS-1:0]  voxel_mem [DEPTH];

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign in_inside = ({3'b000, in_pos_x} < EDGE_C) && ({3'b000, in_pos_y} < EDGE_C) &&
                     ({3'b000, in_pos_z} < EDGE_C);

  // Neighbor coordinates for the direction being read, with the chunk-edge check.
  always_comb begin
    nb_x   = NW'(pos_x_r);
    nb_y   = NW'(pos_y_r);
    nb_z   = NW'(pos_z_r);
    nb_oob = 1'b0;
    unique case (issue_dir_r)
      DIR_LEFT: begin
        nb_oob = (pos_x_r == '0);
        nb_x   = NW'(pos_x_r) - ONE_N;
      end
      DIR_RIGHT: begin
        nb_x   = NW'(pos_x_r) + ONE_N;
        nb_oob = (nb_x == E_N);
      end
      DIR_BOTTOM: begin
        nb_oob = (pos_y_r == '0);
        nb_y   = NW'(pos_y_r) - ONE_N;
      end
      DIR_TOP: begin
        nb_y   = NW'(pos_y_r) + ONE_N;
        nb_oob = (nb_y == E_N);
      end
      DIR_BACK: begin
        nb_oob = (pos_z_r == '0);
        nb_z   = NW'(pos_z_r) - ONE_N;
      end
      DIR_FRONT: begin
        nb_z   = NW'(pos_z_r) + ONE_N;
        nb_oob = (nb_z == E_N);
      end
      default: begin
        nb_oob = 1'b1;
      end
    endcase
  end

  // Store port: clearing sweep, write words and the center read from the
  // input ports, neighbor reads from the sequencer.
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = '0;
    mem_addr  = addr_of(nb_x, nb_y, nb_z);
    priority if (state_r == ST_CLEAR) begin
      mem_we   = 1'b1;
      mem_addr = clr_addr_r;
    end else if (state_r == ST_IDLE) begin
      mem_addr  = addr_of(NW'(in_pos_x), NW'(in_pos_y), NW'(in_pos_z));
      mem_we    = accept && (in_req_type == REQ_WRITE) && in_inside;
      mem_wdata = KIND_BITS'(in_kind_in);
    end else begin
      mem_addr = addr_of(nb_x, nb_y, nb_z);
    end
  end

  // Voxel store, single port with registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      voxel_mem[mem_addr] <= mem_wdata;
    end else begin
      mem_rdata_r <= voxel_mem[mem_addr];
    end
  end

  // Sequencer: center read, six neighbor reads, then one face per cycle.
  always_comb begin
    logic [DIR_W-1:0]    sel_dir;
    logic                sel_found;
    logic [NUM_DIRS-1:0] rest_mask;

    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    pos_x_nxt     = pos_x_r;
    pos_y_nxt     = pos_y_r;
    pos_z_nxt     = pos_z_r;
    issue_dir_nxt = issue_dir_r;
    ret_vld_nxt   = 1'b0;
    ret_dir_nxt   = issue_dir_r;
    ret_oob_nxt   = nb_oob;
    mask_nxt      = mask_r;
    vcount_nxt    = vcount_r;
    color_nxt     = color_r;
    out_valid_nxt = 1'b0;
    out_dir_nxt   = out_dir_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_z_nxt     = out_z_r;
    out_vtx_nxt   = out_vtx_r;
    out_color_nxt = out_color_r;
    out_last_nxt  = out_last_r;

    // Lowest pending face.
    sel_dir   = DIR_LEFT;
    sel_found = 1'b0;
    for (int d = 0; d < NUM_DIRS; d++) begin
      if (!sel_found && mask_r[d]) begin
        sel_found = 1'b1;
        sel_dir   = DIR_W'(d);
      end
    end
    rest_mask          = mask_r;
    rest_mask[sel_dir] = 1'b0;

    unique case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == LAST_A) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_req_type == REQ_START) begin
            vcount_nxt = '0;
            color_nxt  = COLOR_WHITE;
          end else if ((in_req_type == REQ_MESH) && in_inside) begin
            pos_x_nxt     = in_pos_x;
            pos_y_nxt     = in_pos_y;
            pos_z_nxt     = in_pos_z;
            issue_dir_nxt = DIR_LEFT;
            mask_nxt      = '0;
            state_nxt     = ST_CENTER;
          end
        end
      end
      ST_CENTER: begin
        // The read of the left neighbor goes out in this cycle.
        if (mem_rdata_r == '0) begin
          state_nxt = ST_IDLE;
        end else begin
          if (32'(mem_rdata_r) == 32'd1) begin
            color_nxt = COLOR_GREEN;
          end else if (32'(mem_rdata_r) == 32'd2) begin
            color_nxt = COLOR_BLUE;
          end
          ret_vld_nxt   = 1'b1;
          issue_dir_nxt = issue_dir_r + DIR_W'(1);
          state_nxt     = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (issue_dir_r != DIR_END) begin
          ret_vld_nxt   = 1'b1;
          issue_dir_nxt = issue_dir_r + DIR_W'(1);
        end
        if (ret_vld_r) begin
          mask_nxt[ret_dir_r] = ret_oob_r || (mem_rdata_r == '0);
          if (ret_dir_r == DIR_FRONT) begin
            state_nxt = (mask_nxt == '0) ? ST_IDLE : ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        out_valid_nxt = 1'b1;
        out_dir_nxt   = sel_dir;
        out_x_nxt     = pos_x_r;
        out_y_nxt     = pos_y_r;
        out_z_nxt     = pos_z_r;
        out_vtx_nxt   = vcount_r;
        out_color_nxt = color_r;
        out_last_nxt  = (rest_mask == '0);
        vcount_nxt    = vcount_r + VERTS_PER_FACE;
        mask_nxt      = rest_mask;
        if (rest_mask == '0) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      ret_vld_r   <= 1'b0;
      vcount_r    <= '0;
      color_r     <= COLOR_WHITE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      ret_vld_r   <= ret_vld_nxt;
      vcount_r    <= vcount_nxt;
      color_r     <= color_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    pos_x_r     <= pos_x_nxt;
    pos_y_r     <= pos_y_nxt;
    pos_z_r     <= pos_z_nxt;
    issue_dir_r <= issue_dir_nxt;
    ret_dir_r   <= ret_dir_nxt;
    ret_oob_r   <= ret_oob_nxt;
    mask_r      <= mask_nxt;
    out_dir_r   <= out_dir_nxt;
    out_x_r     <= out_x_nxt;
    out_y_r     <= out_y_nxt;
    out_z_r     <= out_z_nxt;
    out_vtx_r   <= out_vtx_nxt;
    out_color_r <= out_color_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_face_dir     = out_dir_r;
  assign out_face_x       = out_x_r;
  assign out_face_y       = out_y_r;
  assign out_face_z       = out_z_r;
  assign out_first_vertex = out_vtx_r;
  assign out_color_sel    = out_color_r;
  assign out_last_face    = out_last_r;

  // A face word only follows a cycle spent emitting.
  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_EMIT))
    else $error("face word without an emit cycle");

  // The last face of a voxel returns the sequencer to idle.
  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (state_r == ST_IDLE))
    else $error("sequencer still active after last face");

  // Faces of one voxel come back to back with the vertex index stepping by four.
  a_vertex_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |=>
      (out_valid_r && (out_vtx_r == VCOUNT_W'($past(out_vtx_r) + VERTS_PER_FACE))))
    else $error("vertex index did not advance by one face");

  // The store is written only by the clearing sweep or by a write word.
  a_write_window: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> ((state_r == ST_CLEAR) || (state_r == ST_IDLE)))
    else $error("store write during a mesh sequence");

endmodule
